// ----- design/sega_pkg.sv -----
package sega_pkg;

  localparam int MAX_SEGS  = 32;
  localparam int IDX_W     = $clog2(MAX_SEGS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_BITS = 16;
  localparam int SIZE_W    = 16;

  localparam logic [SIZE_W-1:0]  ARENA_RESET = SIZE_W'(128);
  localparam logic [SIZE_W+1:0]  ADDR_LIMIT  = (SIZE_W+2)'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] STAT_OK   = 3'd0;
  localparam logic [2:0] STAT_BAD  = 3'd1;
  localparam logic [2:0] STAT_FULL = 3'd2;
  localparam logic [2:0] STAT_ZERO = 3'd3;
  localparam logic [2:0] STAT_OVF  = 3'd4;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_ARENA    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_ERR,
    OP_SCAN,
    OP_SHUP_INIT,
    OP_SHUP,
    OP_WR_SPLIT,
    OP_WR_PICK,
    OP_MARK,
    OP_APPEND,
    OP_FREE_RD,
    OP_NEXT_MERGE,
    OP_PREV_MERGE,
    OP_SHDN,
    OP_SHDN_END
  } dp_op_e;

  typedef enum logic [2:0] {
    RD_SCAN,
    RD_J_DN,
    RD_J_UP,
    RD_N,
    RD_N_NEXT,
    RD_N_PREV
  } rd_sel_e;

  typedef struct packed {
    dp_op_e     op;
    rd_sel_e    rd_sel;
    logic [2:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       fit_mode;
    logic       size_zero;
    logic       idx_bad;
    logic       found;
    logic       split;
    logic       full;
    logic       ovf;
    logic       rd_busy;
    logic       take;
    logic       scan_last;
    logic       has_next;
    logic       has_prev;
    logic       shup_done;
    logic       shdn_done;
  } dp_stat_t;

endpackage

// ----- design/sega_dp.sv -----
module sega_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [sega_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                    req_type_i,
  input  logic [sega_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [sega_pkg::IDX_W-1:0]    block_index_i,
  input  sega_pkg::dp_cmd_t             cmd_i,
  output sega_pkg::dp_stat_t            stat_o,
  output logic [2:0]                    status_o,
  output logic [sega_pkg::SIZE_W-1:0]   block_address_o,
  output logic [sega_pkg::IDX_W-1:0]    result_index_o,
  output logic [sega_pkg::CNT_W-1:0]    segment_count_o
);

  localparam int IW = sega_pkg::IDX_W;
  localparam int CW = sega_pkg::CNT_W;
  localparam int SW = sega_pkg::SIZE_W;

  logic [SW-1:0] start_q [sega_pkg::MAX_SEGS];
  logic [SW-1:0] size_q  [sega_pkg::MAX_SEGS];
  logic [sega_pkg::MAX_SEGS-1:0] busy_q;

  logic          fit_mode_q;
  logic [SW-1:0] arena_q;
  logic [CW-1:0] total_q, i_q, j_q;
  logic [IW-1:0] pick_q, n_q;
  logic [SW-1:0] pick_start_q, pick_size_q, req_size_q;
  logic [1:0]    req_type_q;
  logic          found_q;
  logic [SW:0]   end_q;
  logic [2:0]    res_status_q;
  logic [SW-1:0] res_addr_q;
  logic [IW-1:0] res_idx_q;

  logic [IW-1:0] rd_idx, wr_idx;
  logic [SW-1:0] rd_start, rd_size, wr_start, wr_size;
  logic          rd_busy, wr_en, wr_busy, hit, take;
  logic [SW+1:0] app_end;

  always_comb begin
    case (cmd_i.rd_sel)
      sega_pkg::RD_SCAN:   rd_idx = i_q[IW-1:0];
      sega_pkg::RD_J_DN:   rd_idx = j_q[IW-1:0] - IW'(1);
      sega_pkg::RD_J_UP:   rd_idx = j_q[IW-1:0] + IW'(1);
      sega_pkg::RD_N_NEXT: rd_idx = n_q + IW'(1);
      sega_pkg::RD_N_PREV: rd_idx = n_q - IW'(1);
      default:             rd_idx = n_q;
    endcase
  end

  assign rd_start = start_q[rd_idx];
  assign rd_size  = size_q[rd_idx];
  assign rd_busy  = busy_q[rd_idx];

  assign hit  = !rd_busy && (rd_size >= req_size_q);
  assign take = hit && (!found_q || (fit_mode_q && (rd_size < pick_size_q)));
  assign app_end = {1'b0, end_q} + {2'b00, req_size_q};

  always_comb begin
    stat_o.req_type  = req_type_q;
    stat_o.fit_mode  = fit_mode_q;
    stat_o.size_zero = (req_size_q == '0);
    stat_o.idx_bad   = ({1'b0, n_q} >= total_q);
    stat_o.found     = found_q;
    stat_o.split     = (pick_size_q > req_size_q);
    stat_o.full      = (total_q == CW'(sega_pkg::MAX_SEGS));
    stat_o.ovf       = (app_end > sega_pkg::ADDR_LIMIT);
    stat_o.rd_busy   = rd_busy;
    stat_o.take      = take;
    stat_o.scan_last = ((i_q + CW'(1)) >= total_q);
    stat_o.has_next  = (({1'b0, n_q} + CW'(1)) < total_q);
    stat_o.has_prev  = (n_q != '0);
    stat_o.shup_done = (j_q == ({1'b0, pick_q} + CW'(1)));
    stat_o.shdn_done = ((j_q + CW'(1)) >= total_q);
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = pick_q;
    wr_start = pick_start_q;
    wr_size  = pick_size_q;
    wr_busy  = 1'b0;
    case (cmd_i.op)
      sega_pkg::OP_CLEAR: begin
        wr_en    = 1'b1;
        wr_idx   = '0;
        wr_start = '0;
        wr_size  = arena_q;
      end
      sega_pkg::OP_SHUP, sega_pkg::OP_SHDN: begin
        wr_en    = 1'b1;
        wr_idx   = j_q[IW-1:0];
        wr_start = rd_start;
        wr_size  = rd_size;
        wr_busy  = rd_busy;
      end
      sega_pkg::OP_WR_SPLIT: begin
        wr_en    = 1'b1;
        wr_idx   = pick_q + IW'(1);
        wr_start = pick_start_q + req_size_q;
        wr_size  = pick_size_q - req_size_q;
      end
      sega_pkg::OP_WR_PICK: begin
        wr_en   = 1'b1;
        wr_size = req_size_q;
        wr_busy = 1'b1;
      end
      sega_pkg::OP_MARK: begin
        wr_en   = 1'b1;
        wr_busy = 1'b1;
      end
      sega_pkg::OP_APPEND: begin
        wr_en    = 1'b1;
        wr_idx   = total_q[IW-1:0];
        wr_start = end_q[SW-1:0];
        wr_size  = req_size_q;
        wr_busy  = 1'b1;
      end
      sega_pkg::OP_SHDN_END, sega_pkg::OP_NONE: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_q[wr_idx] <= wr_start;
      size_q[wr_idx]  <= wr_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (wr_en) begin
      busy_q[wr_idx] <= wr_busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
      arena_q    <= sega_pkg::ARENA_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == sega_pkg::CFG_FIT_MODE) begin
        fit_mode_q <= cfg_wdata_i[0];
      end else begin
        arena_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= CW'(1);
      i_q     <= '0;
      j_q     <= '0;
      pick_q  <= '0;
      found_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        sega_pkg::OP_LATCH: begin
          i_q     <= '0;
          found_q <= 1'b0;
        end
        sega_pkg::OP_CLEAR: total_q <= CW'(1);
        sega_pkg::OP_SCAN: begin
          i_q <= i_q + CW'(1);
          if (take) begin
            pick_q  <= i_q[IW-1:0];
            found_q <= 1'b1;
          end
        end
        sega_pkg::OP_SHUP_INIT: j_q <= total_q;
        sega_pkg::OP_SHUP:      j_q <= j_q - CW'(1);
        sega_pkg::OP_SHDN:      j_q <= j_q + CW'(1);
        sega_pkg::OP_SHDN_END:  total_q <= total_q - CW'(1);
        sega_pkg::OP_WR_PICK, sega_pkg::OP_APPEND: total_q <= total_q + CW'(1);
        sega_pkg::OP_FREE_RD:   pick_q <= n_q;
        sega_pkg::OP_NEXT_MERGE: j_q <= {1'b0, n_q} + CW'(1);
        sega_pkg::OP_PREV_MERGE: begin
          j_q    <= {1'b0, n_q};
          pick_q <= n_q - IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sega_pkg::OP_LATCH: begin
        req_type_q <= req_type_i;
        req_size_q <= req_size_i;
        n_q        <= block_index_i;
      end
      sega_pkg::OP_CLEAR: begin
        res_status_q <= sega_pkg::STAT_OK;
        res_addr_q   <= '0;
        res_idx_q    <= '0;
      end
      sega_pkg::OP_ERR: begin
        res_status_q <= cmd_i.err;
        res_addr_q   <= '0;
        res_idx_q    <= '0;
      end
      sega_pkg::OP_SCAN: begin
        end_q <= {1'b0, rd_start} + {1'b0, rd_size};
        if (take) begin
          pick_start_q <= rd_start;
          pick_size_q  <= rd_size;
        end
      end
      sega_pkg::OP_WR_PICK, sega_pkg::OP_MARK: begin
        res_status_q <= sega_pkg::STAT_OK;
        res_addr_q   <= pick_start_q;
        res_idx_q    <= pick_q;
      end
      sega_pkg::OP_APPEND: begin
        res_status_q <= sega_pkg::STAT_OK;
        res_addr_q   <= end_q[SW-1:0];
        res_idx_q    <= total_q[IW-1:0];
      end
      sega_pkg::OP_FREE_RD: begin
        pick_start_q <= rd_start;
        pick_size_q  <= rd_size;
      end
      sega_pkg::OP_NEXT_MERGE: pick_size_q <= pick_size_q + rd_size;
      sega_pkg::OP_PREV_MERGE: begin
        pick_start_q <= rd_start;
        pick_size_q  <= pick_size_q + rd_size;
      end
      sega_pkg::OP_SHDN_END: begin
        res_status_q <= sega_pkg::STAT_OK;
        res_addr_q   <= pick_start_q;
        res_idx_q    <= pick_q;
      end
      sega_pkg::OP_NONE: begin
        res_status_q <= sega_pkg::STAT_OK;
        res_addr_q   <= pick_start_q;
        res_idx_q    <= pick_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o        = res_status_q;
  assign block_address_o = res_addr_q;
  assign result_index_o  = res_idx_q;
  assign segment_count_o = total_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) && (total_q <= CW'(sega_pkg::MAX_SEGS)))
    else $error("segment count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sega_pkg::OP_CLEAR) |=> (total_q == CW'(1)) && !busy_q[0])
    else $error("clear did not leave one free segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sega_pkg::OP_SCAN) && take |=> found_q)
    else $error("scan hit not recorded");

endmodule

// ----- design/sega_ctrl.sv -----
module sega_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  sega_pkg::dp_stat_t stat_i,
  output sega_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SHUP  = 4'd4;
  localparam logic [3:0] S_WRP   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_SHDN1 = 4'd8;
  localparam logic [3:0] S_PREV  = 4'd9;
  localparam logic [3:0] S_SHDN2 = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_INIT  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = sega_pkg::OP_SHDN_END;
    cmd_o.rd_sel = sega_pkg::RD_N;
    cmd_o.err    = sega_pkg::STAT_OK;
    cmd_o.op     = sega_pkg::OP_LATCH;
    if (state_q != S_IDLE) begin
      cmd_o.op = sega_pkg::OP_SCAN;
    end
    case (state_q)
      S_INIT: begin
        cmd_o.op = sega_pkg::OP_CLEAR;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.op = start ? sega_pkg::OP_LATCH : sega_pkg::OP_SHUP_INIT;
        if (start) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d  = S_DONE;
        cmd_o.op = sega_pkg::OP_ERR;
        cmd_o.err = sega_pkg::STAT_BAD;
        case (stat_i.req_type)
          sega_pkg::REQ_ALLOC: begin
            if (stat_i.size_zero) begin
              cmd_o.err = sega_pkg::STAT_ZERO;
            end else begin
              cmd_o.op = sega_pkg::OP_SHUP_INIT;
              state_d  = S_SCAN;
            end
          end
          sega_pkg::REQ_FREE: begin
            if (!stat_i.idx_bad) begin
              cmd_o.op = sega_pkg::OP_SHUP_INIT;
              state_d  = S_FRD;
            end
          end
          sega_pkg::REQ_CLEAR: cmd_o.op = sega_pkg::OP_CLEAR;
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.op     = sega_pkg::OP_SCAN;
        cmd_o.rd_sel = sega_pkg::RD_SCAN;
        if ((stat_i.take && !stat_i.fit_mode) || stat_i.scan_last) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d  = S_DONE;
        cmd_o.op = sega_pkg::OP_ERR;
        cmd_o.err = sega_pkg::STAT_FULL;
        if (stat_i.found) begin
          if (!stat_i.split) begin
            cmd_o.op = sega_pkg::OP_MARK;
          end else if (!stat_i.full) begin
            cmd_o.op = sega_pkg::OP_SHUP_INIT;
            state_d  = S_SHUP;
          end
        end else if (!stat_i.full) begin
          if (stat_i.ovf) begin
            cmd_o.err = sega_pkg::STAT_OVF;
          end else begin
            cmd_o.op = sega_pkg::OP_APPEND;
          end
        end
      end
      S_SHUP: begin
        cmd_o.rd_sel = sega_pkg::RD_J_DN;
        if (stat_i.shup_done) begin
          cmd_o.op = sega_pkg::OP_WR_SPLIT;
          state_d  = S_WRP;
        end else begin
          cmd_o.op = sega_pkg::OP_SHUP;
        end
      end
      S_WRP: begin
        cmd_o.op = sega_pkg::OP_WR_PICK;
        state_d  = S_DONE;
      end
      S_FRD: begin
        cmd_o.rd_sel = sega_pkg::RD_N;
        if (stat_i.rd_busy) begin
          cmd_o.op = sega_pkg::OP_FREE_RD;
          state_d  = S_NEXT;
        end else begin
          cmd_o.op  = sega_pkg::OP_ERR;
          cmd_o.err = sega_pkg::STAT_BAD;
          state_d   = S_DONE;
        end
      end
      S_NEXT: begin
        cmd_o.rd_sel = sega_pkg::RD_N_NEXT;
        if (stat_i.has_next && !stat_i.rd_busy) begin
          cmd_o.op = sega_pkg::OP_NEXT_MERGE;
          state_d  = S_SHDN1;
        end else begin
          cmd_o.op = sega_pkg::OP_SHUP_INIT;
          state_d  = S_PREV;
        end
      end
      S_SHDN1: begin
        cmd_o.rd_sel = sega_pkg::RD_J_UP;
        if (stat_i.shdn_done) begin
          cmd_o.op = sega_pkg::OP_SHDN_END;
          state_d  = S_PREV;
        end else begin
          cmd_o.op = sega_pkg::OP_SHDN;
        end
      end
      S_PREV: begin
        cmd_o.rd_sel = sega_pkg::RD_N_PREV;
        if (stat_i.has_prev && !stat_i.rd_busy) begin
          cmd_o.op = sega_pkg::OP_PREV_MERGE;
          state_d  = S_SHDN2;
        end else begin
          cmd_o.op = sega_pkg::OP_NONE;
          state_d  = S_DONE;
        end
      end
      S_SHDN2: begin
        cmd_o.rd_sel = sega_pkg::RD_J_UP;
        if (stat_i.shdn_done) begin
          cmd_o.op = sega_pkg::OP_SHDN_END;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = sega_pkg::OP_SHDN;
        end
      end
      S_DONE: begin
        cmd_o.op = sega_pkg::OP_SHUP_INIT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);
  assign done = (state_q == S_DONE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_IDLE))
    else $error("result strobe not followed by idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> (state_q == S_DISP))
    else $error("accepted transaction not dispatched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHUP) |-> !stat_i.full)
    else $error("table shift with a full table");

endmodule

// ----- design/segment_allocator_first_best_fit.sv -----
// Segment allocator with first-fit and best-fit placement over a table of
// 32 address-ordered segments. A transaction is taken when start is high and
// busy is low; its result appears for one cycle with done high, and the
// receiver cannot stall it. The placement scan visits table entries one at a
// time, and entries are moved one at a time when a split opens a gap or a
// merge closes one, since the table has a single read and a single write
// port. After reset, busy stays high for one cycle while the initial free
// segment is written. Configuration writes take effect at once, and the
// arena size is used at the next clear.
module segment_allocator_first_best_fit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [sega_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [sega_pkg::SIZE_W-1:0] req_size_i,
  input  logic [sega_pkg::IDX_W-1:0]  block_index_i,
  output logic                        done,
  output logic [2:0]                  status_o,
  output logic [sega_pkg::SIZE_W-1:0] block_address_o,
  output logic [sega_pkg::IDX_W-1:0]  result_index_o,
  output logic [sega_pkg::CNT_W-1:0]  segment_count_o
);

  sega_pkg::dp_cmd_t  cmd;
  sega_pkg::dp_stat_t stat;

  sega_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sega_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .req_size_i      (req_size_i),
    .block_index_i   (block_index_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .result_index_o  (result_index_o),
    .segment_count_o (segment_count_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  status;
  logic [15:0] address;
  logic [4:0]  index;
  logic [5:0]  count;
} alloc_result_t;

class alloc_scoreboard;
  int unsigned seg_base [32];
  int unsigned seg_len [32];
  bit          seg_used [32];
  int unsigned seg_num;
  bit          best_fit;
  int unsigned arena;
  alloc_result_t pending [$];
  int unsigned mismatches;
  int unsigned checked;

  function new();
    best_fit = 0;
    arena = 128;
    mismatches = 0;
    checked = 0;
    reset_table();
  endfunction

  function void reset_table();
    for (int k = 0; k < 32; k++) begin
      seg_base[k] = 0;
      seg_len[k] = 0;
      seg_used[k] = 0;
    end
    seg_len[0] = (arena > 65535) ? 65535 : arena;
    seg_num = 1;
  endfunction

  function void shift_up(int unsigned pos);
    for (int k = seg_num; k > pos; k--) begin
      seg_base[k] = seg_base[k-1];
      seg_len[k] = seg_len[k-1];
      seg_used[k] = seg_used[k-1];
    end
    seg_num++;
  endfunction

  function void shift_down(int unsigned pos);
    for (int k = pos; k + 1 < seg_num; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k] = seg_len[k+1];
      seg_used[k] = seg_used[k+1];
    end
    seg_num--;
  endfunction

  function logic [2:0] allocate(int unsigned sz, output int unsigned addr,
                                output int unsigned idx);
    int unsigned pick;
    int unsigned tail;
    bit found;
    pick = 0;
    found = 0;
    if (sz == 0) return sega_pkg::STAT_ZERO;
    for (int k = 0; k < seg_num; k++) begin
      if (seg_used[k] || seg_len[k] < sz) continue;
      if (!found || (best_fit && seg_len[k] < seg_len[pick])) begin
        pick = k;
        found = 1;
        if (!best_fit) break;
      end
    end
    if (found) begin
      if (seg_len[pick] > sz) begin
        if (seg_num >= 32) return sega_pkg::STAT_FULL;
        shift_up(pick + 1);
        seg_base[pick+1] = seg_base[pick] + sz;
        seg_len[pick+1] = seg_len[pick] - sz;
        seg_used[pick+1] = 0;
        seg_len[pick] = sz;
      end
      seg_used[pick] = 1;
    end else begin
      if (seg_num >= 32) return sega_pkg::STAT_FULL;
      tail = seg_base[seg_num-1] + seg_len[seg_num-1];
      if (tail + sz > 65535) return sega_pkg::STAT_OVF;
      pick = seg_num;
      seg_num++;
      seg_base[pick] = tail;
      seg_len[pick] = sz;
      seg_used[pick] = 1;
    end
    addr = seg_base[pick];
    idx = pick;
    return sega_pkg::STAT_OK;
  endfunction

  function logic [2:0] release_seg(int unsigned n, output int unsigned addr,
                                   output int unsigned idx);
    if (n >= seg_num || !seg_used[n]) return sega_pkg::STAT_BAD;
    seg_used[n] = 0;
    if (n + 1 < seg_num && !seg_used[n+1]) begin
      seg_len[n] += seg_len[n+1];
      shift_down(n + 1);
    end
    if (n > 0 && !seg_used[n-1]) begin
      seg_len[n-1] += seg_len[n];
      shift_down(n);
      n--;
    end
    addr = seg_base[n];
    idx = n;
    return sega_pkg::STAT_OK;
  endfunction

  function void note_request(logic [1:0] kind, logic [15:0] sz, logic [4:0] n);
    alloc_result_t r;
    int unsigned addr;
    int unsigned idx;
    addr = 0;
    idx = 0;
    if (kind == sega_pkg::REQ_ALLOC) r.status = allocate(sz, addr, idx);
    else if (kind == sega_pkg::REQ_FREE) r.status = release_seg(n, addr, idx);
    else if (kind == sega_pkg::REQ_CLEAR) begin
      reset_table();
      r.status = sega_pkg::STAT_OK;
    end else r.status = sega_pkg::STAT_BAD;
    if (r.status != sega_pkg::STAT_OK) begin
      addr = 0;
      idx = 0;
    end
    r.address = addr[15:0];
    r.index = idx[4:0];
    r.count = seg_num[5:0];
    pending.push_back(r);
  endfunction

  function void check_result(alloc_result_t got);
    alloc_result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected transaction result: status %0d addr %0d index %0d count %0d",
                 got.status, got.address, got.index, got.count);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.address !== want.address ||
        got.index !== want.index || got.count !== want.count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result %0d differs: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                 checked, want.status, want.address, want.index, want.count,
                 got.status, got.address, got.index, got.count);
    end
  endfunction
endclass

module testbench;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_addr_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  req_type_i = 0;
  logic [15:0] req_size_i = 0;
  logic [4:0]  block_index_i = 0;
  logic        done;
  logic [2:0]  status_o;
  logic [15:0] block_address_o;
  logic [4:0]  result_index_o;
  logic [5:0]  segment_count_o;

  alloc_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned quiet_cycles;
  int unsigned sent;

  segment_allocator_first_best_fit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i), .start(start), .busy(busy), .req_type_i(req_type_i),
    .req_size_i(req_size_i), .block_index_i(block_index_i), .done(done),
    .status_o(status_o), .block_address_o(block_address_o),
    .result_index_o(result_index_o), .segment_count_o(segment_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    alloc_result_t got;
    if (rst_ni && done) begin
      got.status = status_o;
      got.address = block_address_o;
      got.index = result_index_o;
      got.count = segment_count_o;
      sb.check_result(got);
    end
    if (!rst_ni || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("segment_allocator_first_best_fit: mismatch");
      $finish;
    end
  end

  task automatic issue(logic [1:0] kind, logic [15:0] sz, logic [4:0] n);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(8, 1);
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1;
    req_type_i <= kind;
    req_size_i <= sz;
    block_index_i <= n;
    do @(posedge clk_i); while (busy);
    sb.note_request(kind, sz, n);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [15:0] value);
    cfg_we_i <= 1;
    cfg_addr_i <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (sel == sega_pkg::CFG_FIT_MODE) sb.best_fit = value[0];
    else sb.arena = value;
  endtask

  task automatic random_requests(int unsigned count);
    int unsigned roll;
    int unsigned cap;
    int unsigned used_list [$];
    logic [15:0] sz;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      cap = sb.arena / 6;
      if (cap < 8) cap = 8;
      if (roll < 50) begin
        if ($urandom_range(19) == 0) sz = 16'($urandom);
        else sz = 16'($urandom_range(cap, 1));
        issue(sega_pkg::REQ_ALLOC, sz, 5'($urandom));
      end else if (roll < 95) begin
        used_list.delete();
        for (int j = 0; j < sb.seg_num; j++) if (sb.seg_used[j]) used_list.push_back(j);
        if (used_list.size() != 0 && $urandom_range(9) != 0)
          issue(sega_pkg::REQ_FREE, 16'($urandom),
                5'(used_list[$urandom_range(used_list.size() - 1)]));
        else issue(sega_pkg::REQ_FREE, 16'($urandom), 5'($urandom));
      end else if (roll < 98) issue(sega_pkg::REQ_CLEAR, 16'($urandom), 5'($urandom));
      else issue(2'd3, 16'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    idle_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_reg(sega_pkg::CFG_FIT_MODE, 16'd0);
    write_reg(sega_pkg::CFG_ARENA, 16'd128);

    issue(sega_pkg::REQ_ALLOC, 16'd0, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'hFFFF, 5'd31);
    issue(sega_pkg::REQ_ALLOC, 16'd1, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'd127, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'd5, 5'd0);
    issue(sega_pkg::REQ_FREE, 16'd0, 5'd31);
    issue(sega_pkg::REQ_FREE, 16'd0, 5'd1);
    issue(sega_pkg::REQ_FREE, 16'd0, 5'd1);
    issue(sega_pkg::REQ_FREE, 16'd0, 5'd0);
    issue(sega_pkg::REQ_FREE, 16'd0, 5'd1);
    issue(2'd3, 16'hFFFF, 5'd31);
    issue(sega_pkg::REQ_CLEAR, 16'd0, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'd128, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'd65407, 5'd0);
    issue(sega_pkg::REQ_ALLOC, 16'd1, 5'd0);
    drain();

    idle_pct = 21;
    write_reg(sega_pkg::CFG_ARENA, 16'hFFFF);
    issue(sega_pkg::REQ_CLEAR, 16'd0, 5'd0);
    random_requests(560);
    drain();

    idle_pct = 82;
    write_reg(sega_pkg::CFG_FIT_MODE, 16'd1);
    write_reg(sega_pkg::CFG_ARENA, 16'd1);
    issue(sega_pkg::REQ_CLEAR, 16'd0, 5'd0);
    random_requests(560);
    drain();

    idle_pct = 0;
    write_reg(sega_pkg::CFG_ARENA, 16'($urandom_range(1023, 64)));
    issue(sega_pkg::REQ_CLEAR, 16'd0, 5'd0);
    random_requests(560);
    drain();

    repeat (80) @(posedge clk_i);
    $display("Sent %0d transactions over first fit and best fit, arenas 1 to 65535;",
             sent);
    $display("checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("segment_allocator_first_best_fit: match");
    else
      $display("segment_allocator_first_best_fit: mismatch");
    $finish;
  end
endmodule
